// ----- sv/mbam_pkg.sv -----
// ============================================================================
// mbam_pkg
// Shared types, widths and codes for the bit-vector approximate matcher.
// ============================================================================
package mbam_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int CODE_W      = 4;
    localparam int POS_W       = 31;
    localparam int SCORE_W     = 7;
    localparam int LEN_IDX_W   = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CODES_W     = MAX_PATTERN * CODE_W;

    localparam logic [CODE_W-1:0]  BASE_A    = 4'd1;
    localparam logic [CODE_W-1:0]  BASE_C    = 4'd2;
    localparam logic [CODE_W-1:0]  BASE_G    = 4'd4;
    localparam logic [CODE_W-1:0]  BASE_T    = 4'd8;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODES_0       = 3'd0,
        CFG_CODES_1       = 3'd1,
        CFG_CODES_2       = 3'd2,
        CFG_CODES_3       = 3'd3,
        CFG_PATTERN_LEN   = 3'd4,
        CFG_THRESHOLD     = 3'd5,
        CFG_EXTEND_SAME   = 3'd6,
        CFG_EXTEND_BETTER = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [CODE_W-1:0] base_code;
        logic              last_in_buffer;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]   match_end;
        logic [SCORE_W-1:0] match_score;
    } t_out_item;

    // One of A, C, G or T: matches by containment, not equality.
    function automatic logic is_single_base(input logic [CODE_W-1:0] code);
        return (code == BASE_A) || (code == BASE_C) || (code == BASE_G) ||
               (code == BASE_T);
    endfunction

endpackage

// ----- sv/mbam_step.sv -----
// ============================================================================
// mbam_step
// One Myers bit-vector column step: equality vector, 64-bit add, score update.
// ============================================================================
module mbam_step import mbam_pkg::*; (
    input  logic [CODES_W-1:0]     i_codes,
    input  logic [LEN_IDX_W-1:0]   i_len_m1,
    input  logic [CODE_W-1:0]      i_sym,
    input  logic [MAX_PATTERN-1:0] i_pv,
    input  logic [MAX_PATTERN-1:0] i_mv,
    input  logic [SCORE_W-1:0]     i_score,
    output logic [MAX_PATTERN-1:0] o_pv,
    output logic [MAX_PATTERN-1:0] o_mv,
    output logic [SCORE_W-1:0]     o_score
);

    logic [MAX_PATTERN-1:0] eq_raw;
    logic [MAX_PATTERN-1:0] len_mask;
    logic [MAX_PATTERN-1:0] eq, xv, xh, ph, mh, ph_sh, mh_sh;
    logic                   single;

    assign single   = is_single_base(i_sym);
    assign len_mask = {MAX_PATTERN{1'b1}} >> ((MAX_PATTERN - 1) - int'(i_len_m1));

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_eq
        logic [CODE_W-1:0] code;
        assign code      = i_codes[g*CODE_W +: CODE_W];
        assign eq_raw[g] = single ? ((code & i_sym) != '0) : (code == i_sym);
    end

    assign eq    = eq_raw & len_mask;
    assign xv    = eq | i_mv;
    assign xh    = (((eq & i_pv) + i_pv) ^ i_pv) | eq;
    assign ph    = i_mv | ~(xh | i_pv);
    assign mh    = i_pv & xh;
    assign ph_sh = ph << 1;
    assign mh_sh = mh << 1;
    assign o_pv  = mh_sh | ~(xv | ph_sh);
    assign o_mv  = ph_sh & xv;

    // Score follows the horizontal delta at the last pattern row, saturating.
    always_comb begin
        o_score = i_score;
        if (ph[i_len_m1]) begin
            if (i_score != SCORE_MAX) o_score = i_score + SCORE_W'(1);
        end else if (mh[i_len_m1]) begin
            if (i_score != '0) o_score = i_score - SCORE_W'(1);
        end
    end

endmodule

// ----- sv/myers_bitvector_approx_match_unit.sv -----
// ============================================================================
// myers_bitvector_approx_match_unit
// Streams nucleotide symbols against a pattern of up to 64 IUPAC codes and
// reports end positions and edit distances of approximate matches.
// ============================================================================
//
//  Channel | Direction | Handshake                      | Payload
//  --------+-----------+--------------------------------+----------------------
//  in      | to block  | i_in_valid / o_in_stall        | i_in_data (t_in_item)
//  out     | from blk  | o_out_valid / i_out_stall      | o_out_data (t_out_item)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
//  - One symbol per clock while not stalled: the whole column step (equality
//    vector, one 64-bit add, bitwise logic, score and run bookkeeping) sits
//    between the state registers and the result register, so each result is
//    registered straight from its symbol's transfer (into the skid if held).
//  - Results go to a result register backed by one skid entry; input is only
//    stalled while the skid entry is occupied.
//  - Synchronous active-low reset: scan state restarts, registers take their
//    defaults (length 1, threshold 0, extends off, codes zero).
//  - Config is always ready; a pattern length write restarts the scan.
//
module myers_bitvector_approx_match_unit import mbam_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [CODES_W-1:0]   r_codes;
    logic [LEN_IDX_W-1:0] r_len_m1;      // effective pattern length minus one
    logic [SCORE_W-1:0]   r_threshold;
    logic                 r_extend_same;
    logic                 r_extend_better;

    // Scan state
    logic [MAX_PATTERN-1:0] r_pv, r_mv;
    logic [SCORE_W-1:0]     r_score;
    logic [POS_W-1:0]       r_pos;
    logic                   r_run_open;
    logic [SCORE_W-1:0]     r_held_score;
    logic [POS_W-1:0]       r_held_end;

    // Result register and skid entry
    logic      r_out_v, r_skid_v;
    t_out_item r_out, r_skid;

    logic                   in_xfer, out_xfer, cfg_xfer, cfg_len_wr;
    logic [LEN_IDX_W-1:0]   cfg_len_m1;
    logic [SCORE_W-1:0]     restart_score;
    logic [MAX_PATTERN-1:0] step_pv, step_mv;
    logic [SCORE_W-1:0]     step_score;

    logic                 n_run_open;
    logic [SCORE_W-1:0]   n_held_score;
    logic [POS_W-1:0]     n_held_end;
    logic                 res_v;
    t_out_item            res;
    logic                 extend;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;
    assign cfg_len_wr  = cfg_xfer && (t_cfg_reg'(i_cfg_index) == CFG_PATTERN_LEN);
    assign o_in_stall  = r_skid_v;
    assign in_xfer     = i_in_valid & ~o_in_stall;
    assign out_xfer    = r_out_v & ~i_out_stall;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign extend      = r_extend_same | r_extend_better;

    // Clamp a length write to 1..64 and keep it as length minus one.
    always_comb begin
        priority if (i_cfg_data[SCORE_W-1:0] == '0) begin
            cfg_len_m1 = '0;
        end else if (i_cfg_data[SCORE_W-1:0] > SCORE_W'(MAX_PATTERN)) begin
            cfg_len_m1 = LEN_IDX_W'(MAX_PATTERN - 1);
        end else begin
            cfg_len_m1 = LEN_IDX_W'(i_cfg_data[SCORE_W-1:0] - SCORE_W'(1));
        end
    end

    assign restart_score = SCORE_W'({1'b0, r_len_m1}) + SCORE_W'(1);

    mbam_step u_step (
        .i_codes  (r_codes),
        .i_len_m1 (r_len_m1),
        .i_sym    (i_in_data.base_code),
        .i_pv     (r_pv),
        .i_mv     (r_mv),
        .i_score  (r_score),
        .o_pv     (step_pv),
        .o_mv     (step_mv),
        .o_score  (step_score)
    );

    // Hit and run bookkeeping for the symbol being transferred.
    always_comb begin
        n_run_open   = r_run_open;
        n_held_score = r_held_score;
        n_held_end   = r_held_end;
        res_v        = 1'b0;
        res          = '{match_end: r_held_end, match_score: r_held_score};
        if (step_score <= r_threshold) begin
            if (r_run_open) begin
                priority if (extend && step_score < r_held_score) begin
                    n_held_score = step_score;
                    n_held_end   = r_pos;
                end else if (extend && step_score == r_held_score) begin
                    if (r_extend_same) n_held_end = r_pos;
                end else begin
                    // worse hit, or extends switched off: flush the held hit
                    n_run_open = 1'b0;
                    res_v      = 1'b1;
                end
            end else if (extend) begin
                n_held_score = step_score;
                n_held_end   = r_pos;
                n_run_open   = 1'b1;
            end else begin
                res_v = 1'b1;
                res   = '{match_end: r_pos, match_score: step_score};
            end
        end else if (r_run_open) begin
            n_run_open = 1'b0;
            res_v      = 1'b1;
        end
        // last symbol: flush whatever is still held
        if (i_in_data.last_in_buffer && n_run_open && !res_v) begin
            res_v = 1'b1;
            res   = '{match_end: n_held_end, match_score: n_held_score};
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes         <= '0;
            r_len_m1        <= '0;
            r_threshold     <= '0;
            r_extend_same   <= 1'b0;
            r_extend_better <= 1'b0;
        end else if (cfg_xfer) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_CODES_0:       r_codes[0*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                CFG_CODES_1:       r_codes[1*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                CFG_CODES_2:       r_codes[2*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                CFG_CODES_3:       r_codes[3*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                CFG_PATTERN_LEN:   r_len_m1        <= cfg_len_m1;
                CFG_THRESHOLD:     r_threshold     <= i_cfg_data[SCORE_W-1:0];
                CFG_EXTEND_SAME:   r_extend_same   <= i_cfg_data[0];
                CFG_EXTEND_BETTER: r_extend_better <= i_cfg_data[0];
                default:           r_threshold     <= r_threshold;
            endcase
        end
    end

    // Scan state: restart on reset, on a length write and after a last symbol.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv         <= '1;
            r_mv         <= '0;
            r_score      <= SCORE_W'(1);
            r_pos        <= '0;
            r_run_open   <= 1'b0;
            r_held_score <= '0;
            r_held_end   <= '0;
        end else if (cfg_len_wr) begin
            r_pv         <= '1;
            r_mv         <= '0;
            r_score      <= SCORE_W'({1'b0, cfg_len_m1}) + SCORE_W'(1);
            r_pos        <= '0;
            r_run_open   <= 1'b0;
            r_held_score <= '0;
            r_held_end   <= '0;
        end else if (in_xfer) begin
            if (i_in_data.last_in_buffer) begin
                r_pv         <= '1;
                r_mv         <= '0;
                r_score      <= restart_score;
                r_pos        <= '0;
                r_run_open   <= 1'b0;
                r_held_score <= '0;
                r_held_end   <= '0;
            end else begin
                r_pv         <= step_pv;
                r_mv         <= step_mv;
                r_score      <= step_score;
                r_pos        <= r_pos + POS_W'(1);
                r_run_open   <= n_run_open;
                r_held_score <= n_held_score;
                r_held_end   <= n_held_end;
            end
        end
    end

    // Result register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_xfer) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (r_out_v && !out_xfer) begin
            if (in_xfer && res_v) begin
                r_skid   <= res;
                r_skid_v <= 1'b1;
            end
        end else begin
            r_out_v <= in_xfer & res_v;
            r_out   <= res;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry occupied with result register empty");

    a_score_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_score <= (SCORE_W'({1'b0, r_len_m1}) + SCORE_W'(1)))
        else $error("edit distance above pattern length");

    a_restart_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.last_in_buffer) |=> (r_pos == '0 && !r_run_open))
        else $error("scan not restarted after last symbol");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_in_data.last_in_buffer && !cfg_len_wr)
            |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("text position did not advance");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_out_stall && !r_skid_v && in_xfer && res_v) |=> r_skid_v)
        else $error("result dropped while output stalled");

endmodule
